// ----- sv/binary_fixed_to_decimal_ascii_core_macros.svh -----
// Assertion macros shared by the fixed-point to decimal ASCII converter.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BINARY_FIXED_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_FIXED_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFDA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFDA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bfda_pkg.sv -----
// Types, constants and arithmetic helpers for the decimal ASCII converter.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package bfda_pkg;

    localparam logic [31:0] RAW_LIMIT   = 32'd256000;
    localparam logic [16:0] ROUNDED_MAX = 17'd99999;

    localparam logic [5:0] CH_SPACE = 6'd32;
    localparam logic [5:0] CH_STAR  = 6'd42;
    localparam logic [5:0] CH_POINT = 6'd46;
    localparam logic [5:0] CH_ZERO  = 6'd48;

    // ceil(2^20 / 10); exact quotient for any 17-bit dividend
    localparam logic [16:0] DIV10_RECIP = 17'd104858;

    // Payload carried between pipeline stages. New digits shift in at index 0.
    typedef struct packed {
        logic            oor;
        logic [16:0]     quo;
        logic [3:0][3:0] digs;
    } bfda_stage_t;

    function automatic logic [16:0] div10(input logic [16:0] x);
        logic [33:0] prod;
        prod = 34'(x) * 34'(DIV10_RECIP);
        return 17'(prod[33:20]);
    endfunction

    function automatic logic [5:0] to_ascii(input logic [3:0] d);
        return CH_ZERO | {2'b00, d};
    endfunction

endpackage

`default_nettype wire

// ----- sv/binary_fixed_to_decimal_ascii_core.sv -----
// Top level of the fixed-point to decimal ASCII converter (DDD.DD form).
// Depends on bfda_pkg, bfda_round, bfda_digit and the assertion macro header.
//
// Usage:
//   Input channel in_valid/in_ready carries raw_value, an unsigned value in
//   units of 1/256. Output channel out_valid/out_ready carries six 6-bit
//   ASCII characters and out_of_range. A request is taken on a clock edge
//   where valid and ready are both high.
//   The value is rounded to hundredths. Leading hundreds and tens places
//   show a space; inputs of 256000 or more, and a rounded value above
//   99999, give ***.** with out_of_range set.
//   Structure: five register stages (one rounding stage, four divide-by-ten
//   stages, each a constant-reciprocal multiply); out_valid and the result
//   come straight from the registers of the last stage.
//   Throughput: one request per cycle, sustained, with out_ready high.
//   Stall: when out_ready is low, each stage holds as long as every stage
//   after it is full; in_ready drops only once all five stages are full.
//   Nothing is dropped or repeated.
//   Reset: rst_n clears every stage valid bit; the pipeline comes up empty.
`default_nettype none
`include "binary_fixed_to_decimal_ascii_core_macros.svh"

module binary_fixed_to_decimal_ascii_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] raw_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       char_hundreds,
    output logic [5:0]       char_tens,
    output logic [5:0]       char_ones,
    output logic [5:0]       char_point,
    output logic [5:0]       char_tenths,
    output logic [5:0]       char_hundredths,
    output logic             out_of_range
);

    localparam int NUM_DIGIT = 4;

    logic                  stg_valid [NUM_DIGIT+1];
    logic                  stg_ready [NUM_DIGIT+1];
    bfda_pkg::bfda_stage_t stg_data  [NUM_DIGIT+1];
    bfda_pkg::bfda_stage_t last;
    logic                  tens_blank;
    logic                  hund_blank;

    bfda_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (in_valid),
        .up_ready  (in_ready),
        .raw_value (raw_value),
        .dn_valid  (stg_valid[0]),
        .dn_ready  (stg_ready[0]),
        .dn_data   (stg_data[0])
    );

    for (genvar g = 0; g < NUM_DIGIT; g++)
    begin : g_digit
        bfda_digit u_digit (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[g]),
            .up_ready (stg_ready[g]),
            .up_data  (stg_data[g]),
            .dn_valid (stg_valid[g+1]),
            .dn_ready (stg_ready[g+1]),
            .dn_data  (stg_data[g+1])
        );
    end

    assign stg_ready[NUM_DIGIT] = out_ready;
    assign out_valid            = stg_valid[NUM_DIGIT];
    assign last                 = stg_data[NUM_DIGIT];

    // digs[3] hundredths .. digs[0] tens; quo holds hundreds
    always_comb
    begin
        hund_blank = (last.quo == 17'd0);
        tens_blank = hund_blank && (last.digs[0] == 4'd0);
        char_point = bfda_pkg::CH_POINT;
        out_of_range = last.oor;
        if (last.oor)
        begin
            char_hundreds   = bfda_pkg::CH_STAR;
            char_tens       = bfda_pkg::CH_STAR;
            char_ones       = bfda_pkg::CH_STAR;
            char_tenths     = bfda_pkg::CH_STAR;
            char_hundredths = bfda_pkg::CH_STAR;
        end
        else
        begin
            char_hundreds   = hund_blank ? bfda_pkg::CH_SPACE
                                         : bfda_pkg::to_ascii(last.quo[3:0]);
            char_tens       = tens_blank ? bfda_pkg::CH_SPACE
                                         : bfda_pkg::to_ascii(last.digs[0]);
            char_ones       = bfda_pkg::to_ascii(last.digs[1]);
            char_tenths     = bfda_pkg::to_ascii(last.digs[2]);
            char_hundredths = bfda_pkg::to_ascii(last.digs[3]);
        end
    end

    `BFDA_ASSERT_IMP(a_top_star_ones, clk, rst_n, out_valid && out_of_range,
        char_ones == bfda_pkg::CH_STAR, "error result without star")
    `BFDA_ASSERT_IMP(a_top_ones_digit, clk, rst_n, out_valid && !out_of_range,
        char_ones >= bfda_pkg::CH_ZERO && char_ones <= 6'd57, "ones place not a digit")
    `BFDA_ASSERT_IMP(a_top_blank_order, clk, rst_n, out_valid && !out_of_range &&
        char_hundreds != bfda_pkg::CH_SPACE, char_tens != bfda_pkg::CH_SPACE,
        "tens blanked under a shown hundreds digit")

endmodule

`default_nettype wire

// ----- sv/bfda_round.sv -----
// Entry stage: range check and rounding of the 1/256 input to hundredths.
// Depends on bfda_pkg and the assertion macro header.
`default_nettype none
`include "binary_fixed_to_decimal_ascii_core_macros.svh"

module bfda_round (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire logic [31:0]          raw_value,
    output logic                      dn_valid,
    input  wire logic                 dn_ready,
    output bfda_pkg::bfda_stage_t     dn_data
);

    logic                  v_reg;
    bfda_pkg::bfda_stage_t data_reg;
    bfda_pkg::bfda_stage_t data_next;
    logic [17:0]           raw_lo;
    logic [24:0]           scaled;
    logic [16:0]           rounded;

    // raw * 100 as shift-add, then + 128 and drop eight fraction bits
    always_comb
    begin
        raw_lo  = raw_value[17:0];
        scaled  = {1'b0, raw_lo, 6'b0} + {2'b0, raw_lo, 5'b0} + {5'b0, raw_lo, 2'b0}
                  + 25'd128;
        rounded = scaled[24:8];
        data_next.oor  = (raw_value >= bfda_pkg::RAW_LIMIT) ||
                         (rounded > bfda_pkg::ROUNDED_MAX);
        data_next.quo  = rounded;
        data_next.digs = '0;
    end

    assign up_ready = !v_reg || dn_ready;
    assign dn_valid = v_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    `BFDA_ASSERT_IMP(a_round_in_range, clk, rst_n, v_reg && !data_reg.oor,
        data_reg.quo <= bfda_pkg::ROUNDED_MAX, "in-range value exceeds 99999")

endmodule

`default_nettype wire

// ----- sv/bfda_digit.sv -----
// Digit stage: splits one decimal digit off the running quotient.
// Depends on bfda_pkg and the assertion macro header.
`default_nettype none
`include "binary_fixed_to_decimal_ascii_core_macros.svh"

module bfda_digit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  up_valid,
    output logic                       up_ready,
    input  wire bfda_pkg::bfda_stage_t up_data,
    output logic                       dn_valid,
    input  wire logic                  dn_ready,
    output bfda_pkg::bfda_stage_t      dn_data
);

    logic                  v_reg;
    bfda_pkg::bfda_stage_t data_reg;
    bfda_pkg::bfda_stage_t data_next;
    logic [16:0]           quo10;
    logic [16:0]           times10;
    logic [16:0]           rem_full;

    always_comb
    begin
        quo10    = bfda_pkg::div10(up_data.quo);
        times10  = {quo10[13:0], 3'b0} + {quo10[15:0], 1'b0};
        rem_full = up_data.quo - times10;
        data_next.oor  = up_data.oor;
        data_next.quo  = quo10;
        // shift the finished digit in at the low end
        data_next.digs = {up_data.digs[2:0], rem_full[3:0]};
    end

    assign up_ready = !v_reg || dn_ready;
    assign dn_valid = v_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    `BFDA_ASSERT_IMP(a_digit_decimal, clk, rst_n, v_reg, data_reg.digs[0] <= 4'd9,
        "remainder is not a decimal digit")
    `BFDA_ASSERT_NXT(a_digit_capture, clk, rst_n, up_valid && up_ready, v_reg,
        "accepted request not held in stage")

endmodule

`default_nettype wire

// ----- tb/binary_fixed_to_decimal_ascii_core_tb.sv -----
// Self-checking testbench for binary_fixed_to_decimal_ascii_core (DDD.DD text from 1/256 units).
// Depends on bfda_pkg and the core; a scoreboard class predicts each text result.
// A plain task drives the request channel and an initial block the result channel, with random gaps and stalls.

module binary_fixed_to_decimal_ascii_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_COUNT   = 400;
    localparam int IDLE_PCT     = 29;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 12;
    localparam int STUCK_LIMIT  = 2000;

    typedef struct packed {
        logic [5:0] hundreds;
        logic [5:0] tens;
        logic [5:0] ones;
        logic [5:0] point;
        logic [5:0] tenths;
        logic [5:0] hundredths;
        logic       oor;
    } dec_text_t;

    class dec_text_scoreboard;
        dec_text_t pending_text[$];
        int        mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function dec_text_t format_hundredths(input logic [31:0] raw);
            dec_text_t   t;
            logic [31:0] r;
            logic [31:0] q;
            r = 32'd0;
            t.point = bfda_pkg::CH_POINT;
            if (raw < bfda_pkg::RAW_LIMIT)
                r = (raw * 32'd100 + 32'd128) >> 8;
            if (raw >= bfda_pkg::RAW_LIMIT || r > 32'(bfda_pkg::ROUNDED_MAX)) begin
                t.hundreds   = bfda_pkg::CH_STAR;
                t.tens       = bfda_pkg::CH_STAR;
                t.ones       = bfda_pkg::CH_STAR;
                t.tenths     = bfda_pkg::CH_STAR;
                t.hundredths = bfda_pkg::CH_STAR;
                t.oor        = 1'b1;
                return t;
            end
            t.oor        = 1'b0;
            t.hundredths = bfda_pkg::CH_ZERO + 6'(r % 10);
            r            = r / 10;
            t.tenths     = bfda_pkg::CH_ZERO + 6'(r % 10);
            r            = r / 10;
            t.ones       = bfda_pkg::CH_ZERO + 6'(r % 10);
            q            = r / 10;
            // blank leading places once nothing is left above them
            if (q == 0) begin
                t.tens = bfda_pkg::CH_SPACE;
            end
            else begin
                t.tens = bfda_pkg::CH_ZERO + 6'(q % 10);
                q      = q / 10;
            end
            t.hundreds = (q == 0) ? bfda_pkg::CH_SPACE : bfda_pkg::CH_ZERO + 6'(q % 10);
            return t;
        endfunction

        function void note_request(input logic [31:0] raw);
            pending_text.push_back(format_hundredths(raw));
        endfunction

        function void compare_field(input string name, input logic [5:0] exp_v,
                                    input logic [5:0] act_v);
            if (exp_v !== act_v) begin
                mismatch_count++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(input dec_text_t got);
            dec_text_t exp_t;
            if (pending_text.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            exp_t = pending_text.pop_front();
            compare_field("char_hundreds", exp_t.hundreds, got.hundreds);
            compare_field("char_tens", exp_t.tens, got.tens);
            compare_field("char_ones", exp_t.ones, got.ones);
            compare_field("char_point", exp_t.point, got.point);
            compare_field("char_tenths", exp_t.tenths, got.tenths);
            compare_field("char_hundredths", exp_t.hundredths, got.hundredths);
            compare_field("out_of_range", 6'(exp_t.oor), 6'(got.oor));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] raw_value;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  char_hundreds;
    logic [5:0]  char_tens;
    logic [5:0]  char_ones;
    logic [5:0]  char_point;
    logic [5:0]  char_tenths;
    logic [5:0]  char_hundredths;
    logic        out_of_range;

    dec_text_scoreboard book = new();

    bit sender_gaps;
    bit receiver_gaps;
    int hold_requests;
    int stuck_cycles;

    binary_fixed_to_decimal_ascii_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_value       (raw_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .char_hundreds   (char_hundreds),
        .char_tens       (char_tens),
        .char_ones       (char_ones),
        .char_point      (char_point),
        .char_tenths     (char_tenths),
        .char_hundredths (char_hundredths),
        .out_of_range    (out_of_range)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("** binary_fixed_to_decimal_ascii_core: FAILED **");
            $finish;
        end
    end

    // Result side: check on accept, then pick the next ready level.
    initial begin
        dec_text_t got;
        int        seen_holds;
        int        hold_left;
        out_ready  = 1'b0;
        seen_holds = 0;
        hold_left  = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                got.hundreds   = char_hundreds;
                got.tens       = char_tens;
                got.ones       = char_ones;
                got.point      = char_point;
                got.tenths     = char_tenths;
                got.hundredths = char_hundredths;
                got.oor        = out_of_range;
                book.check_result(got);
            end
            if (hold_requests != seen_holds) begin
                seen_holds = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (receiver_gaps)
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
            else
                out_ready <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_raw();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(255999, 0);
            5:       return $urandom_range(256010, 255990);
            6:       return $urandom_range(300, 0);
            7:       return (($urandom_range(1) == 1) ? 32'd25600 : 32'd2560)
                            + $urandom_range(4) - 32'd2;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(input logic [31:0] val);
        while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
            in_valid  <= 1'b0;
            raw_value <= $urandom();
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        raw_value <= val;
        do @(posedge clk); while (!in_ready);
        book.note_request(val);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (book.pending_text.size() != 0);
    endtask

    initial begin
        logic [31:0] directed[$];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        raw_value     = 32'd0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        hold_requests = 0;
        // rounding edges, blanking edges, inner zero, overflow and limit
        directed = '{32'd0, 32'd1, 32'd2, 32'd127, 32'd128, 32'd100, 32'd2558, 32'd2559,
                     32'd2560, 32'd25598, 32'd25599, 32'd25600, 32'd26880, 32'd38400,
                     32'd12345, 32'd128000, 32'd255998, 32'd255999, 32'd256000,
                     32'd256001, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i]);

        // back-to-back stretch with both sides always ready
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        repeat (100) send_request(pick_raw());

        // long result stall while requests keep coming
        hold_requests++;
        repeat (30) send_request(pick_raw());

        // let every result drain before resuming
        wait_drained();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        repeat (ITEM_COUNT - 130) send_request(pick_raw());

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.mismatch_count == 0 && book.pending_text.size() == 0)
            $display("** binary_fixed_to_decimal_ascii_core: PASSED **");
        else
            $display("** binary_fixed_to_decimal_ascii_core: FAILED **");
        $finish;
    end

endmodule
